// ===== hdl/hed_pkg.sv =====
`timescale 1ns / 1ps

package hed_pkg;

    // default span of one reference, '&' included
    localparam int MAX_REF_SPAN_DEF = 16;

    // depth of the queue between the front and the back
    localparam int QUEUE_DEPTH = 4;

    // characters with a meaning of their own
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // named reference table
    localparam int NAME_COUNT = 63;
    localparam int NAME_MAX   = 6;

    typedef struct packed {
        logic amp;
        logic semi;
    } char_cls_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        char_cls_t  cls;
    } item_t;

    typedef struct packed {
        logic       valid;
        logic       fin;
        logic [7:0] data;
    } emit_cmd_t;

    // label text, last character in the low byte
    localparam logic [47:0] NAME_LABEL [NAME_COUNT] = '{
        "amp", "apos", "quot", "lt", "gt", "nbsp", "copy", "reg", "hellip",
        "ndash", "mdash", "lsquo", "rsquo", "ldquo", "rdquo", "laquo", "raquo",
        "Agrave", "Aacute", "Acirc", "Auml", "Ccedil", "Egrave", "Eacute",
        "Ecirc", "Euml", "Igrave", "Iacute", "Icirc", "Iuml", "Ograve",
        "Oacute", "Ocirc", "Ouml", "Ugrave", "Uacute", "Ucirc", "Uuml",
        "agrave", "aacute", "acirc", "auml", "ccedil", "egrave", "eacute",
        "ecirc", "euml", "igrave", "iacute", "icirc", "iuml", "ograve",
        "oacute", "ocirc", "ouml", "ugrave", "uacute", "ucirc", "uuml",
        "yuml", "oelig", "OElig", "euro"
    };

    localparam logic [2:0] NAME_LEN [NAME_COUNT] = '{
        3'd3, 3'd4, 3'd4, 3'd2, 3'd2, 3'd4, 3'd4, 3'd3, 3'd6,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
        3'd6, 3'd6, 3'd5, 3'd4, 3'd6, 3'd6, 3'd6,
        3'd5, 3'd4, 3'd6, 3'd6, 3'd5, 3'd4, 3'd6,
        3'd6, 3'd5, 3'd4, 3'd6, 3'd6, 3'd5, 3'd4,
        3'd6, 3'd6, 3'd5, 3'd4, 3'd6, 3'd6, 3'd6,
        3'd5, 3'd4, 3'd6, 3'd6, 3'd5, 3'd4, 3'd6,
        3'd6, 3'd5, 3'd4, 3'd6, 3'd6, 3'd5, 3'd4,
        3'd4, 3'd5, 3'd5, 3'd4
    };

    localparam logic [1:0] NAME_VLEN [NAME_COUNT] = '{
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd3, 2'd3, 2'd3,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd2, 2'd2, 2'd2, 2'd3
    };

    // replacement bytes, first byte in the high byte
    localparam logic [23:0] NAME_VAL [NAME_COUNT] = '{
        24'h260000, 24'h270000, 24'h220000, 24'h3C0000, 24'h3E0000,
        24'h200000, 24'h286329, 24'h287229, 24'h2E2E2E,
        24'h2D0000, 24'h2D0000, 24'h270000, 24'h270000, 24'h220000,
        24'h220000, 24'hC2AB00, 24'hC2BB00,
        24'hC38000, 24'hC38100, 24'hC38200, 24'hC38400, 24'hC38700,
        24'hC38800, 24'hC38900, 24'hC38A00, 24'hC38B00, 24'hC38C00,
        24'hC38D00, 24'hC38E00, 24'hC38F00, 24'hC39200, 24'hC39300,
        24'hC39400, 24'hC39600, 24'hC39900, 24'hC39A00, 24'hC39B00,
        24'hC39C00,
        24'hC3A000, 24'hC3A100, 24'hC3A200, 24'hC3A400, 24'hC3A700,
        24'hC3A800, 24'hC3A900, 24'hC3AA00, 24'hC3AB00, 24'hC3AC00,
        24'hC3AD00, 24'hC3AE00, 24'hC3AF00, 24'hC3B200, 24'hC3B300,
        24'hC3B400, 24'hC3B600, 24'hC3B900, 24'hC3BA00, 24'hC3BB00,
        24'hC3BC00,
        24'hC3BF00, 24'hC59300, 24'hC59200, 24'hE282AC
    };

    // character of a label at a position, zero past its end
    function automatic logic [7:0] label_char(input int idx, input int pos);
        int sh;
        sh = (int'(NAME_LEN[idx]) - 1 - pos) * 8;
        if (pos < int'(NAME_LEN[idx]) && sh >= 0) begin
            return NAME_LABEL[idx][sh +: 8];
        end
        return 8'h00;
    endfunction

    // flags for the two characters that steer the parser
    function automatic char_cls_t classify(input logic [7:0] c);
        char_cls_t r;
        r.amp  = (c == CH_AMP);
        r.semi = (c == CH_SEMI);
        return r;
    endfunction

endpackage

// ===== hdl/hed_front.sv =====
`timescale 1ns / 1ps

module hed_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [7:0]       s_in_byte,
    input  logic             s_in_last,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             q_valid,
    output hed_pkg::item_t   q_item,
    input  logic             q_ready
);

    localparam int PTR_W = $clog2(hed_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(hed_pkg::QUEUE_DEPTH + 1);

    hed_pkg::item_t   store_reg [hed_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;
    hed_pkg::item_t   in_item;

    // classify the incoming word
    always_comb begin
        in_item.data = s_in_byte;
        in_item.last = s_in_last;
        in_item.cls  = hed_pkg::classify(s_in_byte);
    end

    assign s_ready = (count_reg != CNT_W'(hed_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = store_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (int'(wr_ptr_reg) == hed_pkg::QUEUE_DEPTH - 1) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (int'(rd_ptr_reg) == hed_pkg::QUEUE_DEPTH - 1) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== hdl/hed_emit.sv =====
`timescale 1ns / 1ps

module hed_emit (
    input  logic                aclk,
    input  logic                aresetn,
    input  hed_pkg::emit_cmd_t  cmd,
    output logic                cmd_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_out_last,
    output logic                m_valid,
    input  logic                m_ready
);

    logic       pend_valid_reg, pend_valid_next;
    logic [7:0] pend_byte_reg, pend_byte_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_byte_reg, m_byte_next;
    logic       m_last_reg, m_last_next;
    logic       slot_free, fire;

    assign slot_free = !m_valid_reg || m_ready;
    assign cmd_ready = !pend_valid_reg || slot_free;
    assign fire      = cmd.valid && cmd_ready;

    // one word is held back until we know whether it ends the step
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_byte_next     = m_byte_reg;
        m_last_next     = m_last_reg;
        if (fire) begin
            if (pend_valid_reg) begin
                m_valid_next = 1'b1;
                m_byte_next  = pend_byte_reg;
                m_last_next  = cmd.fin;
            end
            if (cmd.fin) begin
                pend_valid_next = 1'b0;
            end else begin
                pend_valid_next = 1'b1;
                pend_byte_next  = cmd.data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_byte_reg <= pend_byte_next;
        m_byte_reg    <= m_byte_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_out_last = m_last_reg;

endmodule

// ===== hdl/hed_engine.sv =====
`timescale 1ns / 1ps

module hed_engine #(
    parameter int MAX_REF_SPAN = hed_pkg::MAX_REF_SPAN_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  hed_pkg::item_t      q_item,
    output logic                q_ready,
    output hed_pkg::emit_cmd_t  cmd,
    input  logic                cmd_ready
);

    localparam int HOLD  = MAX_REF_SPAN - 1;
    localparam int LEN_W = $clog2(MAX_REF_SPAN);
    localparam int IDX_W = $clog2(HOLD);
    localparam int CNT_W = $clog2(MAX_REF_SPAN + 1);

    typedef enum logic [8:0] {
        ST_POP   = 9'b000000001,
        ST_FETCH = 9'b000000010,
        ST_BYTE  = 9'b000000100,
        ST_SCAN  = 9'b000001000,
        ST_NUMCK = 9'b000010000,
        ST_REPL  = 9'b000100000,
        ST_LIT   = 9'b001000000,
        ST_END   = 9'b010000000,
        ST_FIN   = 9'b100000000
    } state_t;

    typedef enum logic [4:0] {
        PH_BLANK = 5'b00001,
        PH_PRE   = 5'b00010,
        PH_ZX    = 5'b00100,
        PH_ZX2   = 5'b01000,
        PH_DIG   = 5'b10000
    } phase_t;

    state_t                 state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [7:0]             cur_byte_reg, cur_byte_next;
    hed_pkg::char_cls_t     cur_cls_reg, cur_cls_next;
    logic                   last_reg, last_next;
    logic                   in_ref_reg, in_ref_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [7:0]             buf_reg [HOLD];
    logic [hed_pkg::NAME_COUNT-1:0] mask_reg, mask_next;
    logic                   hash_reg, hash_next;
    logic                   hx_reg, hx_next;
    logic                   replay_reg, replay_next;
    logic [CNT_W-1:0]       rp_reg, rp_next;
    logic [7:0]             tail_reg, tail_next;
    logic [LEN_W-1:0]       scan_i_reg, scan_i_next;
    logic [31:0]            val_reg, val_next;
    logic                   neg_reg, neg_next;
    logic                   any_reg, any_next;
    logic [31:0]            enc_reg, enc_next;
    logic [1:0]             rem_reg, rem_next;
    logic [CNT_W-1:0]       out_k_reg, out_k_next;
    logic                   semi_reg, semi_next;
    logic                   flush_reg, flush_next;

    logic                   buf_we;
    logic [IDX_W-1:0]       rd_idx;
    logic [7:0]             rd_byte;
    logic [CNT_W-1:0]       lit_idx;
    logic                   hex_mode;
    state_t                 after_st;
    logic [hed_pkg::NAME_COUNT-1:0] mask_upd;
    logic                   name_hit;
    logic [23:0]            name_val;
    logic [1:0]             name_vlen;
    logic                   scan_stop;
    phase_t                 scan_ph;
    logic [31:0]            scan_val;
    logic                   scan_any;
    logic                   scan_neg;
    logic [31:0]            cp;
    logic [31:0]            cp_enc;
    logic [1:0]             cp_rem;
    logic                   cp_ok;
    logic [CNT_W-1:0]       lit_end;
    logic [7:0]             lit_byte;

    assign q_ready  = (state_reg == ST_POP);
    assign hex_mode = hx_reg && (len_reg > LEN_W'(2));
    assign lit_idx  = out_k_reg - CNT_W'(1);

    // one read port on the held name
    always_comb begin
        case (state_reg)
            ST_FETCH: rd_idx = rp_reg[IDX_W-1:0];
            ST_SCAN:  rd_idx = scan_i_reg[IDX_W-1:0];
            default:  rd_idx = lit_idx[IDX_W-1:0];
        endcase
    end
    assign rd_byte = (int'(rd_idx) < HOLD) ? buf_reg[rd_idx] : 8'h00;

    // where to go once a byte is fully handled
    assign after_st = (replay_reg && rp_reg != CNT_W'(MAX_REF_SPAN)) ? ST_FETCH : ST_END;

    // named table: candidates narrow as bytes are held
    always_comb begin
        name_hit  = 1'b0;
        name_val  = '0;
        name_vlen = '0;
        for (int n = 0; n < hed_pkg::NAME_COUNT; n++) begin
            if (int'(len_reg) < int'(hed_pkg::NAME_LEN[n])) begin
                mask_upd[n] = mask_reg[n] &&
                    (hed_pkg::label_char(n, int'(len_reg)) == cur_byte_reg);
            end else begin
                mask_upd[n] = 1'b0;
            end
            if (mask_reg[n] && int'(len_reg) == int'(hed_pkg::NAME_LEN[n])) begin
                name_hit  = 1'b1;
                name_val  = name_val | hed_pkg::NAME_VAL[n];
                name_vlen = name_vlen | hed_pkg::NAME_VLEN[n];
            end
        end
    end

    // numeric scan, one held byte a cycle
    always_comb begin
        logic       blank, sign, dec_ok, hex_ok, dig_ok, do_pre, do_dig, is_x;
        logic [3:0] dv;
        blank  = (rd_byte == hed_pkg::CH_SPACE) || (rd_byte >= 8'h09 && rd_byte <= 8'h0D);
        sign   = (rd_byte == hed_pkg::CH_PLUS) || (rd_byte == hed_pkg::CH_MINUS);
        is_x   = (rd_byte == hed_pkg::CH_X_LO) || (rd_byte == hed_pkg::CH_X_UP);
        dec_ok = (rd_byte >= 8'h30 && rd_byte <= 8'h39);
        hex_ok = dec_ok || (rd_byte >= 8'h61 && rd_byte <= 8'h66)
                 || (rd_byte >= 8'h41 && rd_byte <= 8'h46);
        if (dec_ok) begin
            dv = rd_byte[3:0];
        end else begin
            dv = rd_byte[3:0] + 4'd9;
        end
        dig_ok    = hex_mode ? hex_ok : dec_ok;
        do_pre    = 1'b0;
        do_dig    = 1'b0;
        scan_stop = 1'b0;
        scan_ph   = phase_reg;
        scan_val  = val_reg;
        scan_any  = any_reg;
        scan_neg  = neg_reg;
        case (phase_reg)
            PH_BLANK: begin
                if (blank) begin
                    scan_ph = PH_BLANK;
                end else if (sign) begin
                    scan_neg = (rd_byte == hed_pkg::CH_MINUS);
                    scan_ph  = PH_PRE;
                end else begin
                    do_pre = 1'b1;
                end
            end
            PH_PRE: do_pre = 1'b1;
            PH_ZX: begin
                if (is_x) begin
                    scan_ph = PH_ZX2;
                end else begin
                    do_dig = 1'b1;
                end
            end
            PH_ZX2: begin
                if (hex_ok) begin
                    do_dig = 1'b1;
                end else begin
                    scan_stop = 1'b1;
                end
            end
            PH_DIG: do_dig = 1'b1;
            default: scan_stop = 1'b1;
        endcase
        // a leading zero may open a 0x prefix in hex
        if (do_pre) begin
            if (hex_mode && rd_byte == hed_pkg::CH_ZERO) begin
                scan_any = 1'b1;
                scan_ph  = PH_ZX;
            end else begin
                do_dig = 1'b1;
            end
        end
        if (do_dig) begin
            if (dig_ok) begin
                if (hex_mode) begin
                    scan_val = {val_reg[27:0], dv};
                end else begin
                    scan_val = (val_reg << 3) + (val_reg << 1) + {28'd0, dv};
                end
                scan_any = 1'b1;
                scan_ph  = PH_DIG;
            end else begin
                scan_stop = 1'b1;
            end
        end
    end

    // utf-8 encode of the parsed value
    always_comb begin
        cp    = neg_reg ? (32'd0 - val_reg) : val_reg;
        cp_ok = any_reg && (cp <= 32'h0010FFFF);
        if (cp <= 32'h7F) begin
            cp_enc = {cp[7:0], 24'd0};
            cp_rem = 2'd0;
        end else if (cp <= 32'h7FF) begin
            cp_enc = {8'hC0 | {3'd0, cp[10:6]}, 8'h80 | {2'd0, cp[5:0]}, 16'd0};
            cp_rem = 2'd1;
        end else if (cp <= 32'hFFFF) begin
            cp_enc = {8'hE0 | {4'd0, cp[15:12]}, 8'h80 | {2'd0, cp[11:6]},
                      8'h80 | {2'd0, cp[5:0]}, 8'd0};
            cp_rem = 2'd2;
        end else begin
            cp_enc = {8'hF0 | {5'd0, cp[20:18]}, 8'h80 | {2'd0, cp[17:12]},
                      8'h80 | {2'd0, cp[11:6]}, 8'h80 | {2'd0, cp[5:0]}};
            cp_rem = 2'd3;
        end
    end

    // literal output: '&', held bytes, then ';' when closed
    always_comb begin
        lit_end = semi_reg ? (CNT_W'(len_reg) + CNT_W'(1)) : CNT_W'(len_reg);
        if (out_k_reg == '0) begin
            lit_byte = hed_pkg::CH_AMP;
        end else if (out_k_reg <= CNT_W'(len_reg)) begin
            lit_byte = rd_byte;
        end else begin
            lit_byte = hed_pkg::CH_SEMI;
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        cur_byte_next = cur_byte_reg;
        cur_cls_next  = cur_cls_reg;
        last_next     = last_reg;
        in_ref_next   = in_ref_reg;
        len_next      = len_reg;
        mask_next     = mask_reg;
        hash_next     = hash_reg;
        hx_next       = hx_reg;
        replay_next   = replay_reg;
        rp_next       = rp_reg;
        tail_next     = tail_reg;
        scan_i_next   = scan_i_reg;
        val_next      = val_reg;
        neg_next      = neg_reg;
        any_next      = any_reg;
        enc_next      = enc_reg;
        rem_next      = rem_reg;
        out_k_next    = out_k_reg;
        semi_next     = semi_reg;
        flush_next    = flush_reg;
        buf_we        = 1'b0;
        cmd.valid     = 1'b0;
        cmd.fin       = 1'b0;
        cmd.data      = cur_byte_reg;
        case (state_reg)
            ST_POP: begin
                if (q_valid) begin
                    cur_byte_next = q_item.data;
                    cur_cls_next  = q_item.cls;
                    last_next     = q_item.last;
                    replay_next   = 1'b0;
                    state_next    = ST_BYTE;
                end
            end
            // next replayed byte, the overflowing byte comes last
            ST_FETCH: begin
                if (int'(rp_reg) < HOLD) begin
                    cur_byte_next = rd_byte;
                end else begin
                    cur_byte_next = tail_reg;
                end
                cur_cls_next = hed_pkg::classify(cur_byte_next);
                rp_next      = rp_reg + CNT_W'(1);
                state_next   = ST_BYTE;
            end
            ST_BYTE: begin
                if (!in_ref_reg) begin
                    if (cur_cls_reg.amp) begin
                        in_ref_next = 1'b1;
                        len_next    = '0;
                        mask_next   = '1;
                        state_next  = after_st;
                    end else begin
                        cmd.valid = 1'b1;
                        if (cmd_ready) begin
                            state_next = after_st;
                        end
                    end
                end else if (cur_cls_reg.semi) begin
                    out_k_next = '0;
                    flush_next = 1'b0;
                    if (len_reg != '0 && hash_reg) begin
                        scan_i_next = hex_mode ? LEN_W'(2) : LEN_W'(1);
                        phase_next  = PH_BLANK;
                        val_next    = '0;
                        neg_next    = 1'b0;
                        any_next    = 1'b0;
                        state_next  = ST_SCAN;
                    end else if (name_hit) begin
                        enc_next   = {name_val, 8'd0};
                        rem_next   = name_vlen - 2'd1;
                        state_next = ST_REPL;
                    end else begin
                        semi_next  = 1'b1;
                        state_next = ST_LIT;
                    end
                end else if (int'(len_reg) < HOLD) begin
                    buf_we    = 1'b1;
                    mask_next = mask_upd;
                    if (len_reg == '0) begin
                        hash_next = (cur_byte_reg == hed_pkg::CH_HASH);
                    end
                    if (len_reg == LEN_W'(1)) begin
                        hx_next = (cur_byte_reg == hed_pkg::CH_X_LO)
                                  || (cur_byte_reg == hed_pkg::CH_X_UP);
                    end
                    len_next   = len_reg + LEN_W'(1);
                    state_next = after_st;
                end else begin
                    // window full: '&' out, held bytes go round again
                    cmd.valid = 1'b1;
                    cmd.data  = hed_pkg::CH_AMP;
                    if (cmd_ready) begin
                        tail_next   = cur_byte_reg;
                        in_ref_next = 1'b0;
                        len_next    = '0;
                        replay_next = 1'b1;
                        rp_next     = '0;
                        state_next  = ST_FETCH;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_i_reg == len_reg) begin
                    state_next = ST_NUMCK;
                end else begin
                    phase_next = scan_ph;
                    val_next   = scan_val;
                    any_next   = scan_any;
                    neg_next   = scan_neg;
                    if (scan_stop) begin
                        state_next = ST_NUMCK;
                    end else begin
                        scan_i_next = scan_i_reg + LEN_W'(1);
                    end
                end
            end
            ST_NUMCK: begin
                if (cp_ok) begin
                    enc_next   = cp_enc;
                    rem_next   = cp_rem;
                    state_next = ST_REPL;
                end else begin
                    semi_next  = 1'b1;
                    state_next = ST_LIT;
                end
            end
            ST_REPL: begin
                cmd.valid = 1'b1;
                cmd.data  = enc_reg[31:24];
                if (cmd_ready) begin
                    if (rem_reg == '0) begin
                        in_ref_next = 1'b0;
                        len_next    = '0;
                        state_next  = after_st;
                    end else begin
                        enc_next = {enc_reg[23:0], 8'd0};
                        rem_next = rem_reg - 2'd1;
                    end
                end
            end
            ST_LIT: begin
                cmd.valid = 1'b1;
                cmd.data  = lit_byte;
                if (cmd_ready) begin
                    if (out_k_reg == lit_end) begin
                        in_ref_next = 1'b0;
                        len_next    = '0;
                        state_next  = flush_reg ? ST_FIN : after_st;
                    end else begin
                        out_k_next = out_k_reg + CNT_W'(1);
                    end
                end
            end
            // end of the word: flush a pending reference on the last one
            ST_END: begin
                replay_next = 1'b0;
                if (last_reg && in_ref_reg) begin
                    semi_next  = 1'b0;
                    flush_next = 1'b1;
                    out_k_next = '0;
                    state_next = ST_LIT;
                end else begin
                    if (last_reg) begin
                        in_ref_next = 1'b0;
                        len_next    = '0;
                    end
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.valid = 1'b1;
                cmd.fin   = 1'b1;
                if (cmd_ready) begin
                    flush_next = 1'b0;
                    state_next = ST_POP;
                end
            end
            default: state_next = ST_POP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_POP;
            in_ref_reg <= 1'b0;
            len_reg    <= '0;
            replay_reg <= 1'b0;
            flush_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            in_ref_reg <= in_ref_next;
            len_reg    <= len_next;
            replay_reg <= replay_next;
            flush_reg  <= flush_next;
        end
    end

    always_ff @(posedge aclk) begin
        phase_reg    <= phase_next;
        cur_byte_reg <= cur_byte_next;
        cur_cls_reg  <= cur_cls_next;
        last_reg     <= last_next;
        mask_reg     <= mask_next;
        hash_reg     <= hash_next;
        hx_reg       <= hx_next;
        rp_reg       <= rp_next;
        tail_reg     <= tail_next;
        scan_i_reg   <= scan_i_next;
        val_reg      <= val_next;
        neg_reg      <= neg_next;
        any_reg      <= any_next;
        enc_reg      <= enc_next;
        rem_reg      <= rem_next;
        out_k_reg    <= out_k_next;
        semi_reg     <= semi_next;
        if (buf_we) begin
            buf_reg[len_reg[IDX_W-1:0]] <= cur_byte_reg;
        end
    end

endmodule

// ===== hdl/html_entity_decoder.sv =====
`timescale 1ns / 1ps
// a plain byte passes the queue, the engine byte register, the emit hold and output registers
// a plain byte is popped, handled, checked for end of word and closed by the last flag before the next pop
// a closing ';' emits one output word at a time; a numeric one first scans one held byte a cycle
// and then finishes the scan and checks the value
// a full window replays the held bytes, each fetched then handled, through the same sequencer
// reset (aresetn low, synchronous) empties the queue and clears the parser state

module html_entity_decoder #(
    parameter int MAX_REF_SPAN = hed_pkg::MAX_REF_SPAN_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    input  logic       s_valid,
    output logic       s_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_last,
    output logic       m_valid,
    input  logic       m_ready
);

    logic               q_valid;
    logic               q_ready;
    hed_pkg::item_t     q_item;
    hed_pkg::emit_cmd_t emit_cmd;
    logic               cmd_ready;

    // accept and classify
    hed_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_in_byte (s_in_byte),
        .s_in_last (s_in_last),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_ready   (q_ready)
    );

    // reference parsing and replacement
    hed_engine #(
        .MAX_REF_SPAN (MAX_REF_SPAN)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_ready   (q_ready),
        .cmd       (emit_cmd),
        .cmd_ready (cmd_ready)
    );

    // output register with last-word marking
    hed_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (emit_cmd),
        .cmd_ready  (cmd_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready)
    );

`ifndef SYNTHESIS
    // a pushed word is visible to the back on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> q_valid)
        else $error("queue empty right after a push");

    // output only loads from an accepted emit command
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(emit_cmd.valid && cmd_ready))
        else $error("output loaded without an emit command");

    // closing the step for a popped byte returns the back to fetching
    assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_cmd.valid && emit_cmd.fin && cmd_ready) |=> q_ready)
        else $error("engine did not return to fetch after end of word");
`endif

endmodule
